// ===== hw/rtl/lirg_pkg.sv =====
// ----------------------------------------------------------------------------
// lirg_pkg: shared types and constants of the linear resampler
// Sample and result transfer types, configuration bundle, register indexes
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lirg_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int RATE_W       = 18;
	localparam int GAIN_W       = 17;
	localparam int GAIN_FRAC    = 16;
	localparam int GAIN_ROUND   = (1 << GAIN_FRAC) - 1;
	localparam int MAX_RESULTS  = 16;
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

	// Budget is (ahead+1)*out_rate - phase; it never reaches 2*2^RATE_W.
	localparam int BUDGET_W     = RATE_W + 1;
	localparam int AHEAD_W      = RATE_W + 3;
	localparam int ACC_W        = SAMPLE_BITS + RATE_W + 1;
	localparam int DIV_W        = SAMPLE_BITS + RATE_W;
	localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

	localparam int IN_RATE_RST  = 22050;
	localparam int OUT_RATE_RST = 16000;
	localparam int GAIN_RST     = 65536;

	localparam int NUM_REGS     = 3;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W    = APB_ADDR_W - 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IN_RATE  = 0,
		REG_OUT_RATE = 1,
		REG_GAIN     = 2
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          chunk_last;
	} src_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          run_last;
	} dst_item_t;

	// Effective settings: a rate of zero already reads as one here.
	typedef struct packed {
		logic [RATE_W-1:0] in_rate;
		logic [RATE_W-1:0] out_rate;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic restart;
		logic mul_lo;
		logic mul_hi;
		logic div_val;
		logic val_take;
		logic gain_mul;
		logic gain_take;
		logic div_step;
		logic step_take;
		logic emit;
		logic emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic go;
		logic div_done;
		logic out_free;
		logic last;
		logic gain_on;
	} dp_status_t;

endpackage

// ===== hw/rtl/lirg_regs.sv =====
// ----------------------------------------------------------------------------
// lirg_regs: configuration registers
// APB register file for the two rates and the gain. A rate write asks for
// the current chunk to be restarted.
// ----------------------------------------------------------------------------
module lirg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lirg_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [lirg_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [lirg_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output lirg_pkg::cfg_t                       cfg,
	output logic                                 restart
);

	localparam int RW = lirg_pkg::RATE_W;
	localparam int GW = lirg_pkg::GAIN_W;
	localparam int DW = lirg_pkg::APB_DATA_W;

	logic [RW-1:0]        in_rate_q;
	logic [RW-1:0]        out_rate_q;
	logic [GW-1:0]        gain_q;
	logic                 wr;
	lirg_pkg::reg_idx_t   idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = lirg_pkg::reg_idx_t'(paddr[lirg_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q  <= RW'(lirg_pkg::IN_RATE_RST);
			out_rate_q <= RW'(lirg_pkg::OUT_RATE_RST);
			gain_q     <= GW'(lirg_pkg::GAIN_RST);
		end else if (wr) begin
			unique case (idx)
				lirg_pkg::REG_IN_RATE:  in_rate_q  <= pwdata[RW-1:0];
				lirg_pkg::REG_OUT_RATE: out_rate_q <= pwdata[RW-1:0];
				lirg_pkg::REG_GAIN:     gain_q     <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lirg_pkg::REG_IN_RATE:  prdata = DW'(in_rate_q);
			lirg_pkg::REG_OUT_RATE: prdata = DW'(out_rate_q);
			lirg_pkg::REG_GAIN:     prdata = DW'(gain_q);
			default:                prdata = '0;
		endcase
	end

	assign restart = wr && (idx == lirg_pkg::REG_IN_RATE || idx == lirg_pkg::REG_OUT_RATE);

	assign cfg.in_rate  = (in_rate_q == '0) ? RW'(1) : in_rate_q;
	assign cfg.out_rate = (out_rate_q == '0) ? RW'(1) : out_rate_q;
	assign cfg.gain     = gain_q;

endmodule

// ===== hw/rtl/lirg_div.sv =====
// ----------------------------------------------------------------------------
// lirg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. done pulses for one cycle
// when quotient and remainder are ready; they then hold until the next start.
// ----------------------------------------------------------------------------
module lirg_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lirg_pkg::DIV_W-1:0]        dividend,
	input  logic [lirg_pkg::RATE_W-1:0]       divisor,
	output logic                              done,
	output logic [lirg_pkg::DIV_W-1:0]        quotient,
	output logic [lirg_pkg::RATE_W-1:0]       remainder
);

	localparam int W  = lirg_pkg::DIV_W;
	localparam int RW = lirg_pkg::RATE_W;
	localparam int CW = lirg_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [RW:0]   shifted;
	logic [RW+1:0] diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The partial remainder stays below the divisor, so it fits in RATE_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[RW+1]) begin
				rem_q <= diff[RW-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[RW-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/lirg_dp.sv =====
// ----------------------------------------------------------------------------
// lirg_dp: resampler datapath
// Holds the interpolation state, one shared multiplier, the divider and the
// output register. Every register update is ordered by the controller.
// ----------------------------------------------------------------------------
module lirg_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lirg_pkg::cfg_t         cfg,
	input  lirg_pkg::dp_cmd_t      cmd,
	output lirg_pkg::dp_status_t   status,
	input  lirg_pkg::src_item_t    src_data,
	output logic                   dst_valid,
	input  logic                   dst_stall,
	output lirg_pkg::dst_item_t    dst_data
);

	localparam int SB = lirg_pkg::SAMPLE_BITS;
	localparam int RW = lirg_pkg::RATE_W;
	localparam int BW = lirg_pkg::BUDGET_W;
	localparam int AW = lirg_pkg::AHEAD_W;
	localparam int CW = lirg_pkg::ACC_W;
	localparam int DW = lirg_pkg::DIV_W;
	localparam int GF = lirg_pkg::GAIN_FRAC;

	logic signed [SB-1:0] held_q;
	logic signed [SB-1:0] hi_q;
	logic signed [SB-1:0] newest_q;
	logic                 last_q;
	logic signed [AW-1:0] ahead_q;
	logic [RW-1:0]        phase_q;
	logic [BW-1:0]        budget_q;
	logic signed [CW-1:0] acc_q;
	logic                 neg_q;
	logic signed [SB-1:0] val_q;
	logic                 dst_valid_q;
	lirg_pkg::dst_item_t  dst_data_q;

	logic signed [SB-1:0] mul_a;
	logic [RW-1:0]        mul_b;
	logic signed [CW-1:0] product;
	logic signed [SB-1:0] hi_sel;
	logic                 ahead_ge1;
	logic                 ahead_zero;
	logic signed [AW-1:0] ahead_inc;
	logic signed [AW-1:0] ahead_dec;
	logic [CW-1:0]        acc_mag;
	logic signed [CW-1:0] acc_round;
	logic [DW-1:0]        step_num;
	logic                 div_start;
	logic [DW-1:0]        div_dividend;
	logic                 div_done;
	logic [DW-1:0]        div_quo;
	logic [RW-1:0]        div_rem;
	logic [SB:0]          quo_mag;
	logic [SB:0]          quo_neg;

	assign ahead_ge1  = !ahead_q[AW-1] && (ahead_q != '0);
	assign ahead_zero = (ahead_q == '0);
	assign hi_sel     = ahead_ge1 ? hi_q : held_q;
	assign ahead_inc  = ahead_q + AW'(1);
	assign ahead_dec  = ahead_q - AW'(div_quo);

	// One multiplier serves both interpolation terms and the gain.
	always_comb begin
		if (cmd.mul_hi) begin
			mul_a = hi_sel;
			mul_b = phase_q;
		end else if (cmd.gain_mul) begin
			mul_a = val_q;
			mul_b = RW'(cfg.gain);
		end else begin
			mul_a = held_q;
			mul_b = cfg.out_rate - phase_q;
		end
	end

	assign product   = mul_a * $signed({1'b0, mul_b});
	assign acc_mag   = acc_q[CW-1] ? -acc_q : acc_q;
	// Adding one less than unity before the shift truncates negatives toward zero.
	assign acc_round = acc_q + (acc_q[CW-1] ? CW'(lirg_pkg::GAIN_ROUND) : '0);
	assign step_num  = DW'(phase_q) + DW'(cfg.in_rate);

	assign div_start    = cmd.div_val | cmd.div_step;
	assign div_dividend = cmd.div_step ? step_num : acc_mag[DW-1:0];

	assign quo_mag = div_quo[SB:0];
	assign quo_neg = -quo_mag;

	lirg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (cfg.out_rate),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			hi_q     <= '0;
			ahead_q  <= '1;
			phase_q  <= '0;
			budget_q <= '0;
			last_q   <= 1'b0;
		end else if (cmd.restart) begin
			held_q   <= '0;
			hi_q     <= '0;
			ahead_q  <= '1;
			phase_q  <= '0;
			budget_q <= '0;
		end else if (cmd.accept) begin
			ahead_q  <= ahead_inc;
			budget_q <= budget_q + BW'(cfg.out_rate);
			last_q   <= src_data.chunk_last;
			if (ahead_inc == '0) begin
				held_q <= src_data.sample;
			end else if (ahead_inc == AW'(1)) begin
				hi_q <= src_data.sample;
			end
		end else if (cmd.step_take) begin
			ahead_q  <= ahead_dec;
			phase_q  <= div_rem;
			budget_q <= budget_q - BW'(cfg.in_rate);
			if ((div_quo != '0) && (ahead_dec == '0)) begin
				held_q <= newest_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			newest_q <= src_data.sample;
		end
		if (cmd.mul_lo || cmd.gain_mul) begin
			acc_q <= product;
		end else if (cmd.mul_hi) begin
			acc_q <= acc_q + product;
		end
		if (cmd.div_val) begin
			neg_q <= acc_q[CW-1];
		end
		if (cmd.val_take) begin
			val_q <= neg_q ? quo_neg[SB-1:0] : quo_mag[SB-1:0];
		end else if (cmd.gain_take) begin
			val_q <= acc_round[GF+SB-1:GF];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dst_data_q.out_sample <= val_q;
			dst_data_q.run_last   <= cmd.emit_last;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	assign status.go       = (ahead_ge1 || (last_q && ahead_zero))
		&& ({1'b0, cfg.in_rate} <= budget_q);
	assign status.div_done = div_done;
	assign status.out_free = !dst_valid_q || !dst_stall;
	assign status.last     = last_q;
	assign status.gain_on  = !cfg.gain[lirg_pkg::GAIN_W-1];

endmodule

// ===== hw/rtl/lirg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lirg_ctrl: resampler controller
// Sequences one input sample: decides whether another result is due, walks
// the datapath through interpolation, gain (only with gain_on) and position
// update, and places each finished result in the output register.
// ----------------------------------------------------------------------------
module lirg_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  logic                   cfg_restart,
	input  lirg_pkg::dp_status_t   status,
	output lirg_pkg::dp_cmd_t      cmd
);

	localparam int NW = lirg_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_VDIV,
		ST_VWAIT,
		ST_GMUL,
		ST_GSHIFT,
		ST_SDIV,
		ST_SWAIT
	} state_t;

	state_t        state_q;
	logic          src_stall_q;
	logic [NW-1:0] cnt_q;
	logic          pending_q;
	logic          val_due_q;
	logic          accept;
	logic          check_ok;
	logic [NW-1:0] cnt_next;

	assign accept   = (state_q == ST_IDLE) && src_valid && !src_stall_q;
	// A computed result waits here until the output register can take it.
	assign check_ok = !pending_q || status.out_free;
	assign cnt_next = cnt_q + NW'(pending_q);

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		unique case (state_q)
			ST_IDLE: cmd.restart = cfg_restart;
			ST_CHECK: begin
				if (check_ok) begin
					cmd.emit      = pending_q;
					cmd.emit_last = !status.go
						|| (cnt_q == NW'(lirg_pkg::MAX_RESULTS - 1));
					cmd.restart   = !status.go && status.last;
				end
			end
			ST_MUL_LO: cmd.mul_lo    = 1'b1;
			ST_MUL_HI: cmd.mul_hi    = 1'b1;
			ST_VDIV:   cmd.div_val   = 1'b1;
			ST_VWAIT:  cmd.val_take  = status.div_done;
			ST_GMUL:   cmd.gain_mul  = 1'b1;
			ST_GSHIFT: cmd.gain_take = 1'b1;
			ST_SDIV:   cmd.div_step  = 1'b1;
			ST_SWAIT:  cmd.step_take = status.div_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			src_stall_q <= 1'b0;
			cnt_q       <= '0;
			pending_q   <= 1'b0;
			val_due_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_CHECK;
						src_stall_q <= 1'b1;
						cnt_q       <= '0;
						pending_q   <= 1'b0;
					end
				end
				ST_CHECK: begin
					if (check_ok) begin
						cnt_q     <= cnt_next;
						pending_q <= 1'b0;
						if (status.go) begin
							// Past the result limit the position still advances.
							if (cnt_next < NW'(lirg_pkg::MAX_RESULTS)) begin
								state_q   <= ST_MUL_LO;
								val_due_q <= 1'b1;
							end else begin
								state_q   <= ST_SDIV;
								val_due_q <= 1'b0;
							end
						end else begin
							state_q     <= ST_IDLE;
							src_stall_q <= 1'b0;
						end
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_VDIV;
				ST_VDIV:   state_q <= ST_VWAIT;
				ST_VWAIT: begin
					if (status.div_done) begin
						state_q <= status.gain_on ? ST_GMUL : ST_SDIV;
					end
				end
				ST_GMUL:   state_q <= ST_GSHIFT;
				ST_GSHIFT: state_q <= ST_SDIV;
				ST_SDIV:   state_q <= ST_SWAIT;
				ST_SWAIT: begin
					if (status.div_done) begin
						pending_q <= val_due_q;
						state_q   <= ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign src_stall = src_stall_q;

endmodule

// ===== hw/rtl/linear_interp_resampler_with_gain.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_with_gain: linear interpolation resampler
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Source samples arrive on the src channel, one per transfer, the final
// sample of a chunk flagged by chunk_last. Each sample gives zero or more
// resampled results on the dst channel; run_last marks the last result that
// belongs to that sample. The APB port sets in_rate, out_rate and gain; a
// rate write made while no sample is being processed restarts the current chunk.
// Each result runs the bit-serial divider twice, once for the interpolated
// value and once for the position step; the gain multiply is skipped when
// gain bit 16 is set, as at unity gain. Results beyond sixteen for one
// sample are dropped and cost only the step division.
// After reset the registers hold 22050, 16000 and unity gain and no chunk is
// in progress. A stalled dst channel holds the result in the output register;
// the block finishes its current result and then waits, keeping src stalled.
// The next sample is taken while the last result still waits in that register.
// ----------------------------------------------------------------------------
module linear_interp_resampler_with_gain (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lirg_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lirg_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lirg_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              src_valid,
	output logic                              src_stall,
	input  lirg_pkg::src_item_t               src_data,
	output logic                              dst_valid,
	input  logic                              dst_stall,
	output lirg_pkg::dst_item_t               dst_data
);

	lirg_pkg::cfg_t       cfg;
	lirg_pkg::dp_cmd_t    cmd;
	lirg_pkg::dp_status_t status;
	logic                 cfg_restart;

	lirg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (cfg_restart)
	);

	lirg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.cfg_restart (cfg_restart),
		.status      (status),
		.cmd         (cmd)
	);

	lirg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	// Once a sample is taken, no further sample may enter until it is finished.
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall) |=> src_stall)
		else $error("sample transfer was not followed by a stall");

	// A result must never overwrite one that the receiver has not yet taken.
	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result written while the output register was occupied");

	// The shared multiplier serves one operand pair per cycle.
	a_mul_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_lo, cmd.mul_hi, cmd.gain_mul}))
		else $error("multiplier claimed by more than one operation");

endmodule
